@@ rtl/gws_pkg.sv @@
// Package for the greatest word selector: constants, types and bank addressing.
package gws_pkg;

  localparam int MAX_LEN = 32;
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int MEM_DEPTH = 2 * MAX_LEN;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam logic [7:0] SPACE_CHAR = 8'd32;

  typedef enum logic [1:0] {
    CMP_EQUAL,
    CMP_LESS,
    CMP_GREATER
  } cmp_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit_start;
    logic emit_step;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic emit_final;
  } status_t;

  function automatic logic [ADDR_W-1:0] bank_addr(input logic sel, input logic [LEN_W-1:0] pos);
    logic [ADDR_W-1:0] p;
    p = (pos < LEN_W'(MAX_LEN)) ? ADDR_W'(pos) : '0;
    return sel ? ADDR_W'(MAX_LEN) + p : p;
  endfunction

endpackage

@@ rtl/greatest_word_selector.sv @@
// Top level of the greatest word selector.
//
//  channel  valid      stall      payload
//  in       in_valid   in_stall   byte_in, string_end
//  out      out_valid  out_stall  byte_out, run_last, no_word, was_truncated
//
// One input beat per cycle while words are read; the compare uses a bank
// read prefetched by the word memory's registered port.
// A string end beat starts emission: one output beat per cycle unless stalled,
// best-word length beats (one for an empty string); input stalls until the last is loaded.
// Output stall holds the output register and pauses emission.
// Reset is synchronous; the word banks are not cleared.
module greatest_word_selector (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  input  logic       string_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic       run_last,
  output logic       no_word,
  output logic       was_truncated
);
  import gws_pkg::*;

  cmd_t cmd;
  status_t status;

  gws_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .string_end (string_end),
    .status     (status),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  gws_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .byte_in       (byte_in),
    .string_end    (string_end),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_out      (byte_out),
    .run_last      (run_last),
    .no_word       (no_word),
    .was_truncated (was_truncated)
  );

endmodule

@@ rtl/gws_ctrl.sv @@
// Controller state machine: input acceptance and emission sequencing.
module gws_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            string_end,
  input  gws_pkg::status_t status,
  output logic            in_stall,
  output gws_pkg::cmd_t   cmd
);
  import gws_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall = 1'b0;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && string_end) begin
          cmd.emit_start = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        in_stall = 1'b1;
        cmd.emit_step = status.slot_free;
        if (status.slot_free && status.emit_final) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    cmd.emit_next = (state_next == ST_EMIT);
  end

endmodule

@@ rtl/gws_dp.sv @@
// Datapath: word banks, incremental compare, swap and output register.
module gws_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       byte_in,
  input  logic             string_end,
  input  gws_pkg::cmd_t    cmd,
  output gws_pkg::status_t status,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       byte_out,
  output logic             run_last,
  output logic             no_word,
  output logic             was_truncated
);
  import gws_pkg::*;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic wr_en;

  logic sel, sel_next;
  logic [LEN_W-1:0] blen, blen_next;
  logic [LEN_W-1:0] clen, clen_next;
  cmp_t cmp, cmp_next;
  logic ovf, ovf_next;
  logic [LEN_W-1:0] idx, idx_next;

  logic [LEN_W-1:0] len_t;
  cmp_t cmp_t1;
  logic is_space;

  assign status.slot_free = !out_valid || !out_stall;
  assign status.emit_final = (blen == '0) || (idx + LEN_W'(1) == blen);

  always_comb begin
    is_space = (byte_in == SPACE_CHAR);
    sel_next = sel;
    blen_next = blen;
    clen_next = clen;
    cmp_next = cmp;
    ovf_next = ovf;
    wr_en = 1'b0;
    wr_addr = bank_addr(~sel, clen);
    len_t = clen;
    cmp_t1 = cmp;
    if (cmd.accept) begin
      if (!is_space) begin
        if (clen >= LEN_W'(MAX_LEN)) begin
          ovf_next = 1'b1;
        end else begin
          if (cmp == CMP_EQUAL) begin
            priority if (clen >= blen) begin
              cmp_t1 = CMP_GREATER;
            end else if (byte_in > rd_data) begin
              cmp_t1 = CMP_GREATER;
            end else if (byte_in < rd_data) begin
              cmp_t1 = CMP_LESS;
            end else begin
              cmp_t1 = CMP_EQUAL;
            end
          end
          wr_en = 1'b1;
          len_t = clen + LEN_W'(1);
        end
      end
      clen_next = len_t;
      cmp_next = cmp_t1;
      if (is_space || string_end) begin
        if (len_t != '0 && cmp_t1 == CMP_GREATER) begin
          sel_next = ~sel;
          blen_next = len_t;
        end
        clen_next = '0;
        cmp_next = CMP_EQUAL;
      end
    end
    if (cmd.emit_step && status.emit_final) begin
      blen_next = '0;
    end
    priority if (cmd.emit_start) begin
      idx_next = '0;
    end else if (cmd.emit_step) begin
      idx_next = idx + LEN_W'(1);
    end else begin
      idx_next = idx;
    end
    rd_addr = cmd.emit_next ? bank_addr(sel_next, idx_next) : bank_addr(sel_next, clen_next);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= byte_in;
    end
    rd_data <= (wr_en && wr_addr == rd_addr) ? byte_in : mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
      blen <= '0;
      clen <= '0;
      cmp <= CMP_EQUAL;
      ovf <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      sel <= sel_next;
      blen <= blen_next;
      clen <= clen_next;
      cmp <= cmp_next;
      ovf <= ovf_next;
      idx <= idx_next;
      if (cmd.emit_step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      byte_out <= (blen == '0) ? 8'd0 : rd_data;
      run_last <= status.emit_final;
      no_word <= (blen == '0);
      was_truncated <= ovf;
    end
  end

endmodule

@@ dv/tb_greatest_word_selector.sv @@
// Self-checking testbench for greatest_word_selector: directed and random strings.
module tb_greatest_word_selector;
  timeunit 1ns;
  timeprecision 1ps;
  import gws_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
    logic       trunc;
  } word_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    word_beat_t want;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] byte_in;
  logic       string_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] byte_out;
  logic       run_last;
  logic       no_word;
  logic       was_truncated;

  // tracker of the greatest word
  logic [7:0] word_bank [2][MAX_LEN];
  bit         best_sel;
  int         best_len;
  int         cur_len;
  cmp_t       cmp_state;
  logic       ovf_seen;

  word_beat_t greatest_q[$];
  word_beat_t seen_beat;
  word_beat_t want_beat;
  int         mismatches;
  int         sent_items;
  bit         idle_on;
  bit         paused;

  // directed strings; typed rows carry their single result
  dir_row_t dir_rows [26] = '{
    '{" ",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{"a", 1'b0, 1'b0, '0}, '{"b", 1'b0, 1'b0, '0}, '{" ", 1'b0, 1'b0, '0},
    '{" ", 1'b0, 1'b0, '0}, '{"a", 1'b0, 1'b0, '0}, '{"b", 1'b0, 1'b0, '0},
    '{" ", 1'b0, 1'b0, '0}, '{"a", 1'b0, 1'b0, '0}, '{"c", 1'b1, 1'b0, '0},
    '{"z", 1'b0, 1'b0, '0}, '{"y", 1'b0, 1'b0, '0}, '{" ", 1'b0, 1'b0, '0},
    '{"z", 1'b0, 1'b0, '0}, '{"y", 1'b0, 1'b0, '0}, '{"x", 1'b1, 1'b0, '0},
    '{"q", 1'b0, 1'b0, '0}, '{" ", 1'b1, 1'b0, '0},
    '{" ", 1'b0, 1'b0, '0},
    '{" ",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{"b", 1'b0, 1'b0, '0}, '{"a", 1'b0, 1'b0, '0}, '{" ", 1'b0, 1'b0, '0},
    '{"b", 1'b1, 1'b0, '0}
  };

  greatest_word_selector dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_in       (byte_in),
    .string_end    (string_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_out      (byte_out),
    .run_last      (run_last),
    .no_word       (no_word),
    .was_truncated (was_truncated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  function automatic void close_word();
    if (cur_len > 0 && cmp_state == CMP_GREATER) begin
      best_sel = ~best_sel;
      best_len = cur_len;
    end
    cur_len   = 0;
    cmp_state = CMP_EQUAL;
  endfunction

  task automatic update_greatest(input logic [7:0] b, input logic fin, input bit record);
    if (b == SPACE_CHAR) begin
      close_word();
    end else if (cur_len >= MAX_LEN) begin
      ovf_seen = 1'b1;
    end else begin
      if (cmp_state == CMP_EQUAL) begin
        if (cur_len >= best_len) begin
          cmp_state = CMP_GREATER;
        end else if (b > word_bank[best_sel][cur_len]) begin
          cmp_state = CMP_GREATER;
        end else if (b < word_bank[best_sel][cur_len]) begin
          cmp_state = CMP_LESS;
        end
      end
      word_bank[~best_sel][cur_len] = b;
      cur_len++;
    end
    if (fin) begin
      close_word();
      if (record) begin
        if (best_len == 0) begin
          greatest_q.push_back('{8'h00, 1'b1, 1'b1, ovf_seen});
        end else begin
          for (int i = 0; i < best_len; i++) begin
            greatest_q.push_back('{word_bank[best_sel][i], i == best_len - 1, 1'b0, ovf_seen});
          end
        end
      end
      best_len  = 0;
      cur_len   = 0;
      cmp_state = CMP_EQUAL;
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic fin, input bit record);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    byte_in    <= b;
    string_end <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    update_greatest(b, fin, record);
  endtask

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return "a" + 8'($urandom_range(0, 3));
    do c = 8'($urandom_range(0, 255)); while (c == SPACE_CHAR);
    return c;
  endfunction

  task automatic send_string();
    logic [7:0] s[$];
    logic [7:0] word[$];
    logic [7:0] prev[$];
    int         n_words;
    int         len;
    n_words = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    if ($urandom_range(0, 3) == 0) s.push_back(SPACE_CHAR);
    for (int w = 0; w < n_words; w++) begin
      if (w > 0) repeat ($urandom_range(1, 3)) s.push_back(SPACE_CHAR);
      if (w > 0 && $urandom_range(0, 2) == 0) begin
        word = prev;
        case ($urandom_range(0, 2))
          1: word.push_back(rand_char());
          2: word[word.size() - 1] = rand_char();
          default: ;
        endcase
      end else begin
        word.delete();
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(MAX_LEN - 2, MAX_LEN + 6)
                                           : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) word.push_back(rand_char());
      end
      foreach (word[i]) s.push_back(word[i]);
      prev = word;
    end
    if (n_words == 0 || $urandom_range(0, 3) == 0) s.push_back(SPACE_CHAR);
    foreach (s[i]) send_beat(s[i], i == s.size() - 1, 1'b1);
  endtask

  task automatic report_mismatch(input word_beat_t want, input word_beat_t got, input bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan) begin
        $display("unexpected beat: byte=%02h last=%0b empty=%0b trunc=%0b",
                 got.ch, got.last, got.empty, got.trunc);
      end else begin
        $display("beat mismatch: exp byte=%02h last=%0b empty=%0b trunc=%0b",
                 want.ch, want.last, want.empty, want.trunc);
        $display("               got byte=%02h last=%0b empty=%0b trunc=%0b",
                 got.ch, got.last, got.empty, got.trunc);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_beat = '{byte_out, run_last, no_word, was_truncated};
      if (greatest_q.size() == 0) begin
        report_mismatch('0, seen_beat, 1'b1);
      end else begin
        want_beat = greatest_q.pop_front();
        if (seen_beat.last !== want_beat.last || seen_beat.empty !== want_beat.empty ||
            seen_beat.trunc !== want_beat.trunc ||
            (!want_beat.empty && seen_beat.ch !== want_beat.ch)) begin
          report_mismatch(want_beat, seen_beat, 1'b0);
        end
      end
    end
  end

  // output stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    byte_in    = 8'h00;
    string_end = 1'b0;
    mismatches = 0;
    sent_items = 0;
    idle_on    = 1'b1;
    paused     = 1'b0;
    best_sel   = 1'b0;
    best_len   = 0;
    cur_len    = 0;
    cmp_state  = CMP_EQUAL;
    ovf_seen   = 1'b0;
    foreach (word_bank[i, j]) word_bank[i][j] = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].ch, dir_rows[i].fin, !dir_rows[i].typed);
      if (dir_rows[i].typed) greatest_q.push_back(dir_rows[i].want);
    end

    while (sent_items < 260) begin
      idle_on = (sent_items < 220) && ($urandom_range(0, 3) != 0);
      if (!paused && sent_items >= 130) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (greatest_q.size() != 0);
      end
      send_string();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (greatest_q.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && greatest_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
